// ----- sv/kpq_pkg.sv -----
package kpq_pkg;

  localparam int HANDLE_W = 32;
  localparam int DEST_W   = 32;
  localparam int COUNT_W  = 6;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_RELEASE  = 2'd1,
    ACT_DISCARD  = 2'd2,
    ACT_DROP_ALL = 2'd3
  } action_t;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef enum logic {
    VERDICT_ACCEPT = 1'b0,
    VERDICT_DROP   = 1'b1
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_WALK_START,
    ST_CHECK,
    ST_SUMMARY
  } state_t;

  typedef struct packed {
    logic capture;
    logic add_commit;
    logic rd_issue;
    logic keep_write;
    logic emit_verdict;
    logic emit_summary;
    logic walk_finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk_more;
    logic match;
  } status_t;

endpackage

// ----- sv/kpq_ctrl.sv -----
module kpq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_is_add,
  input  kpq_pkg::status_t status,
  output logic            idle,
  output kpq_pkg::cmd_t   cmd
);
  import kpq_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   advance;

  assign advance = !status.match || status.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_is_add ? ST_ADD : ST_WALK_START;
        end
      end
      ST_ADD: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK_START: begin
        state_nxt = status.walk_more ? ST_CHECK : ST_SUMMARY;
      end
      ST_CHECK: begin
        if (advance) begin
          state_nxt = status.walk_more ? ST_CHECK : ST_SUMMARY;
        end
      end
      ST_SUMMARY: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idle = (state_r == ST_IDLE);
    cmd  = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
      end
      ST_ADD: begin
        cmd.add_commit = status.out_free;
      end
      ST_WALK_START: begin
        cmd.rd_issue = status.walk_more;
      end
      ST_CHECK: begin
        cmd.rd_issue     = advance && status.walk_more;
        cmd.keep_write   = !status.match;
        cmd.emit_verdict = status.match && status.out_free;
      end
      ST_SUMMARY: begin
        cmd.emit_summary = status.out_free;
        cmd.walk_finish  = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- sv/kpq_dp.sv -----
module kpq_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kpq_pkg::cmd_t                    cmd,
  output kpq_pkg::status_t                 status,
  input  logic [1:0]                       in_action,
  input  logic [kpq_pkg::HANDLE_W-1:0]     in_packet_handle,
  input  logic [kpq_pkg::DEST_W-1:0]       in_destination,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_result_kind,
  output logic                             out_verdict,
  output logic [kpq_pkg::HANDLE_W-1:0]     out_released_handle,
  output logic [kpq_pkg::COUNT_W-1:0]      out_released_count,
  output logic                             out_full_error,
  output logic                             out_last
);
  import kpq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);

  logic [HANDLE_W-1:0] handle_mem [CAPACITY];
  logic [DEST_W-1:0]   dest_mem   [CAPACITY];

  action_t             action_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [DEST_W-1:0]   key_r;
  logic [OW-1:0]       occ_r;
  logic [OW-1:0]       rd_ptr_r;
  logic [OW-1:0]       kept_r;
  logic [HANDLE_W-1:0] rd_handle_r;
  logic [DEST_W-1:0]   rd_dest_r;

  logic                out_valid_r;
  logic                out_kind_r;
  logic                out_verdict_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_full_r;
  logic                out_last_r;

  logic                full;
  logic                mem_we;
  logic [AW-1:0]       wr_addr;
  logic [HANDLE_W-1:0] wr_handle;
  logic [DEST_W-1:0]   wr_dest;
  logic [OW-1:0]       released;

  assign full     = (occ_r == OW'(CAPACITY));
  assign released = occ_r - kept_r;

  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.walk_more = (rd_ptr_r != occ_r);
  assign status.match     = (action_r == ACT_DROP_ALL) || (rd_dest_r == key_r);

  // add appends at occupancy, walk compacts survivors down to kept
  always_comb begin
    mem_we    = (cmd.add_commit && !full) || cmd.keep_write;
    wr_addr   = cmd.keep_write ? kept_r[AW-1:0] : occ_r[AW-1:0];
    wr_handle = cmd.keep_write ? rd_handle_r : handle_r;
    wr_dest   = cmd.keep_write ? rd_dest_r : key_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      handle_mem[wr_addr] <= wr_handle;
      dest_mem[wr_addr]   <= wr_dest;
    end
    if (cmd.rd_issue) begin
      rd_handle_r <= handle_mem[rd_ptr_r[AW-1:0]];
      rd_dest_r   <= dest_mem[rd_ptr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= action_t'(in_action);
      handle_r <= in_packet_handle;
      key_r    <= in_destination;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      rd_ptr_r <= '0;
      kept_r   <= '0;
    end else begin
      if (cmd.capture) begin
        rd_ptr_r <= '0;
        kept_r   <= '0;
      end else begin
        if (cmd.rd_issue) begin
          rd_ptr_r <= rd_ptr_r + OW'(1);
        end
        if (cmd.keep_write) begin
          kept_r <= kept_r + OW'(1);
        end
      end
      if (cmd.add_commit && !full) begin
        occ_r <= occ_r + OW'(1);
      end else if (cmd.walk_finish) begin
        occ_r <= kept_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_verdict || cmd.emit_summary || cmd.add_commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_verdict) begin
      out_kind_r    <= KIND_VERDICT;
      out_verdict_r <= (action_r == ACT_RELEASE) ? VERDICT_ACCEPT : VERDICT_DROP;
      out_handle_r  <= rd_handle_r;
      out_count_r   <= '0;
      out_full_r    <= 1'b0;
      out_last_r    <= 1'b0;
    end else if (cmd.emit_summary) begin
      out_kind_r    <= KIND_SUMMARY;
      out_verdict_r <= VERDICT_ACCEPT;
      out_handle_r  <= '0;
      out_count_r   <= COUNT_W'(released);
      out_full_r    <= 1'b0;
      out_last_r    <= 1'b1;
    end else if (cmd.add_commit) begin
      out_kind_r    <= KIND_SUMMARY;
      out_verdict_r <= VERDICT_ACCEPT;
      out_handle_r  <= '0;
      out_count_r   <= '0;
      out_full_r    <= full;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_verdict         = out_verdict_r;
  assign out_released_handle = out_handle_r;
  assign out_released_count  = out_count_r;
  assign out_full_error      = out_full_r;
  assign out_last            = out_last_r;

endmodule

// ----- sv/keyed_release_packet_queue.sv -----
// an add is captured, then commits and gives its summary once the result register is free
// release, discard and drop-all walk the buffer one buffer entry per cycle through
// the single read port of the entry memory, except while a matching entry waits
// on a stalled result channel; one transaction is in work at a time
// reset empties the buffer and clears the result valid flag; entry contents
// are not cleared
module keyed_release_packet_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [kpq_pkg::HANDLE_W-1:0] in_packet_handle,
  input  logic [kpq_pkg::DEST_W-1:0]   in_destination,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_result_kind,
  output logic                         out_verdict,
  output logic [kpq_pkg::HANDLE_W-1:0] out_released_handle,
  output logic [kpq_pkg::COUNT_W-1:0]  out_released_count,
  output logic                         out_full_error,
  output logic                         out_last
);
  import kpq_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    idle;
  logic    in_is_add;

  assign in_is_add = (action_t'(in_action) == ACT_ADD);
  assign in_stall  = !idle;

  kpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_is_add (in_is_add),
    .status    (status),
    .idle      (idle),
    .cmd       (cmd)
  );

  kpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_action           (in_action),
    .in_packet_handle    (in_packet_handle),
    .in_destination      (in_destination),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_verdict         (out_verdict),
    .out_released_handle (out_released_handle),
    .out_released_count  (out_released_count),
    .out_full_error      (out_full_error),
    .out_last            (out_last)
  );

endmodule
